@@ hdl/sha256_pkg.sv @@
// ----------------------------------------------------------------------------
// sha256_pkg
// Types, constants and round functions shared by the stream hasher modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       is_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        len_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic       take_byte;   // store byte, bump count
    logic       pad_start;   // write 0x80 and zero tail
    logic       pad_len;     // write length into tail
    logic       clr_head;    // zero bytes 0..55
    logic       load_vars;   // a..h <= chain
    logic       do_round;
    logic       fold;        // chain += a..h
    logic       restart;     // back to initial state
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;  // count mod 64 becomes zero with the next byte
    logic [5:0] pos;
    logic       round_last;
  } dp_stat_t;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos  = 6'd56;
  localparam logic [60:0] CountMax = {61{1'b1}};

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

@@ hdl/sha256_stream_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
// a byte that does not end a block is taken in idle; a block-ending byte starts
// a compression (the rounds, then one fold), run by the single round unit
// a last item: a pad state, then the rounds and a fold per compression, before
// the first digest word is valid, then 8 words at 1/cycle while out_ready_i is high
// asynchronous active-low reset loads the initial hash and clears the count
module sha256_stream_hasher import sha256_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] chain [8];
  logic        ovf;
  logic [2:0]  widx;

  sha256_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .word_idx_o(widx), .stat_i(stat), .cmd_o(cmd)
  );

  sha256_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .byte_i(in_item_i.data_byte),
    .stat_o(stat), .chain_o(chain), .ovf_o(ovf)
  );

  assign out_item_o.digest_word  = chain[widx];
  assign out_item_o.word_index   = widx;
  assign out_item_o.last_word    = (widx == 3'd7);
  assign out_item_o.len_overflow = ovf;

endmodule

@@ hdl/sha256_datapath.sv @@
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer, byte count, schedule window, round registers and chain words.
// ----------------------------------------------------------------------------
module sha256_datapath import sha256_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_cmd_t         cmd_i,
  input  logic [7:0]      byte_i,
  output dp_stat_t        stat_o,
  output logic [31:0]     chain_o [8],
  output logic            ovf_o
);

  // block buffer kept as 16 big-endian words
  logic [31:0] blk_q [16];
  logic [60:0] count_q, count_d;
  logic        ovf_q, ovf_d;
  logic [31:0] w_q [16];
  logic [31:0] v_q [8];
  logic [31:0] h_q [8];
  logic [5:0]  rnd_q;
  logic [31:0] w_cur, t1, t2;
  logic [63:0] bits;
  logic [5:0]  pos;
  logic [3:0]  widx;

  assign pos  = count_q[5:0];
  assign bits = {count_q, 3'b000};
  assign widx = rnd_q[3:0];

  always_comb begin
    if (rnd_q < 6'd16) begin
      w_cur = blk_q[widx];
    end else begin
      w_cur = w_q[widx] + sig0(w_q[widx + 4'd1]) + w_q[widx + 4'd9]
            + sig1(w_q[widx + 4'd14]);
    end
    t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + RoundK[rnd_q] + w_cur;
    t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.restart) begin
      count_d = '0;
      ovf_d   = 1'b0;
    end else if (cmd_i.take_byte) begin
      count_d = count_q + 61'd1;
      if (count_q == CountMax) ovf_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      rnd_q   <= '0;
      for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      if (cmd_i.load_vars) rnd_q <= '0;
      else if (cmd_i.do_round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.restart) begin
        for (int j = 0; j < 8; j++) h_q[j] <= InitHash[j];
      end else if (cmd_i.fold) begin
        for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
      end
    end
  end

  // payload storage, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_byte) begin
      for (int b = 0; b < 4; b++) begin
        if (pos[1:0] == 2'(b)) blk_q[pos[5:2]][8*(3-b) +: 8] <= byte_i;
      end
    end
    if (cmd_i.pad_start) begin
      for (int wi = 0; wi < 16; wi++) begin
        for (int b = 0; b < 4; b++) begin
          if ({4'(wi), 2'(b)} == pos) blk_q[wi][8*(3-b) +: 8] <= PadByte;
          else if ({4'(wi), 2'(b)} > pos) blk_q[wi][8*(3-b) +: 8] <= 8'h00;
        end
      end
    end
    if (cmd_i.clr_head) begin
      for (int wi = 0; wi < 14; wi++) blk_q[wi] <= 32'h0;
    end
    if (cmd_i.pad_len) begin
      blk_q[14] <= bits[63:32];
      blk_q[15] <= bits[31:0];
    end
    if (cmd_i.load_vars) begin
      for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
    end else if (cmd_i.do_round) begin
      w_q[widx] <= w_cur;
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign stat_o.block_full = (count_q[5:0] == 6'd63);
  assign stat_o.pos        = pos;
  assign stat_o.round_last = (rnd_q == 6'd63);
  assign chain_o           = h_q;
  assign ovf_o             = ovf_q;

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q && !cmd_i.restart |=> ovf_q) else $error("overflow flag dropped");
  a_round_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_vars |=> rnd_q == 6'd0) else $error("round count not cleared");
  a_no_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.take_byte && cmd_i.do_round)) else $error("byte write during rounds");

endmodule

@@ hdl/sha256_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequences byte intake, padding, compressions and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  word_idx_o,
  input  dp_stat_t    stat_i,
  output dp_cmd_t     cmd_o
);

  // phase after a compression: 0 plain block, 1 first pad block, 2 final block
  typedef enum logic [1:0] {PH_DATA, PH_PAD1, PH_FINAL} phase_e;

  ctrl_state_e state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        last_q, last_d;   // message ends after current data block
  logic [2:0]  widx_q, widx_d;
  logic        accept;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    last_d  = last_q;
    widx_d  = widx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_item_i.has_byte && stat_i.block_full) begin
            state_d = ST_ROUND;
            phase_d = PH_DATA;
            last_d  = in_item_i.is_last;
          end else if (in_item_i.is_last) begin
            state_d = ST_PAD;
          end
        end
      end
      // count already holds the last byte here
      ST_PAD: begin
        state_d = ST_ROUND;
        phase_d = (stat_i.pos >= LenPos) ? PH_PAD1 : PH_FINAL;
      end
      ST_LOAD: begin
        state_d = ST_ROUND;
        phase_d = PH_FINAL;
      end
      ST_ROUND: if (stat_i.round_last) state_d = ST_FOLD;
      ST_FOLD: begin
        unique case (phase_q)
          PH_DATA: begin
            if (last_q) begin
              state_d = ST_PAD;
              last_d  = 1'b0;
            end else begin
              state_d = ST_IDLE;
            end
          end
          PH_PAD1: state_d = ST_LOAD;
          default: begin
            state_d = ST_EMIT;
            widx_d  = '0;
          end
        endcase
      end
      ST_EMIT: begin
        if (out_ready_i) begin
          widx_d = widx_q + 3'd1;
          if (widx_q == 3'd7) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_EMIT);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.take_byte = in_item_i.has_byte;
          if (in_item_i.has_byte && stat_i.block_full) cmd_o.load_vars = 1'b1;
        end
      end
      ST_PAD: begin
        cmd_o.pad_start = 1'b1;
        cmd_o.pad_len   = (stat_i.pos < LenPos);
        cmd_o.load_vars = 1'b1;
      end
      // second pad block: zero head, length in tail
      ST_LOAD: begin
        cmd_o.clr_head  = 1'b1;
        cmd_o.pad_len   = 1'b1;
        cmd_o.load_vars = 1'b1;
      end
      ST_ROUND: cmd_o.do_round = 1'b1;
      ST_FOLD: cmd_o.fold = 1'b1;
      ST_EMIT: cmd_o.restart = out_ready_i && (widx_q == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_DATA;
      last_q  <= 1'b0;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      last_q  <= last_d;
      widx_q  <= widx_d;
    end
  end

  assign word_idx_o = widx_q;

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input taken while emitting");
  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(widx_q))
    else $error("digest word moved while stalled");
  a_fold_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FOLD |=> state_q != ST_FOLD) else $error("double fold");

endmodule
